@@ src/dual_motor_ramp_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dual motor ramp sequencer
// Clocked property checks that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_RAMP_SEQUENCER_ASSERT_SVH
`define DUAL_MOTOR_RAMP_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge while reset is low.
`define DMRS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, during reset too.
`define DMRS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DMRS_ASSERT(name, clk, rst, prop, msg)
`define DMRS_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

@@ src/dmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual motor ramp sequencer package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package dmrs_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_MODE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_STEP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_STEP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_STEP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TURN_UP_STEP = 3'd5;

  localparam logic [2:0] REQ_MS_TICK   = 3'd0;
  localparam logic [2:0] REQ_HOLD_TICK = 3'd1;
  localparam logic [2:0] REQ_MOVE      = 3'd2;
  localparam logic [2:0] REQ_TURN      = 3'd3;
  localparam logic [2:0] REQ_STOP      = 3'd4;

  localparam logic [6:0]  FULL_POWER  = 7'd100;
  localparam logic [15:0] HOLD_MAX    = 16'hFFFF;
  // floor(x / 100) == (x * 5243) >> 19 for every x up to 100 * 255.
  localparam logic [12:0] RECIP_MUL   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_MOVE_RAMP = 3'd1,
    PH_MOVE_HOLD = 3'd2,
    PH_STOP_FAST = 3'd3,
    PH_STOP_SLOW = 3'd4,
    PH_TURN_PRE  = 3'd5,
    PH_TURN_UP   = 3'd6,
    PH_TURN_HOLD = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] pwm_period;
    logic       brake_mode;
    logic [7:0] move_step_ms;
    logic [7:0] fast_stop_step_ms;
    logic [7:0] slow_stop_step_ms;
    logic [7:0] turn_up_step_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        direction;
    logic [6:0]  target_power;
    logic [15:0] duration_ticks;
    logic        timed;
    logic        slow_stop;
  } req_t;

  typedef struct packed {
    logic [6:0] power;
    logic       left_dir;
    logic       right_dir;
    logic       busy;
  } drive_t;

  typedef struct packed {
    logic [7:0] left_pos_duty;
    logic [7:0] left_neg_duty;
    logic [7:0] right_pos_duty;
    logic [7:0] right_neg_duty;
    logic [6:0] power_pct;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic load_b;
    logic load_c;
    logic load_d;
  } pipe_ctl_t;

endpackage

@@ src/dmrs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register bank for the PWM and ramp step settings.
// ----------------------------------------------------------------------------
module dmrs_cfg_regs
  import dmrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period        <= 8'd99;
      cfg.brake_mode        <= 1'b0;
      cfg.move_step_ms      <= 8'd5;
      cfg.fast_stop_step_ms <= 8'd1;
      cfg.slow_stop_step_ms <= 8'd5;
      cfg.turn_up_step_ms   <= 8'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PWM_PERIOD:   cfg.pwm_period        <= cfg_data;
        CFG_BRAKE_MODE:   cfg.brake_mode        <= cfg_data[0];
        CFG_MOVE_STEP:    cfg.move_step_ms      <= cfg_data;
        CFG_FAST_STEP:    cfg.fast_stop_step_ms <= cfg_data;
        CFG_SLOW_STEP:    cfg.slow_stop_step_ms <= cfg_data;
        CFG_TURN_UP_STEP: cfg.turn_up_step_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/dmrs_ramp_core.sv @@
// ----------------------------------------------------------------------------
// Ramp sequencer core
// Applies one request to the sequencer state, settles finished phases and
// registers the resulting power and directions.
// ----------------------------------------------------------------------------
module dmrs_ramp_core
  import dmrs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  req_t   req,
  input  logic   upd,
  output drive_t drive
);

  `include "dual_motor_ramp_sequencer_assert.svh"

  typedef struct packed {
    phase_t      phase;
    logic [6:0]  power_level;
    logic [6:0]  goal_power;
    logic        left_dir;
    logic        right_dir;
    logic [7:0]  step_count;
    logic [15:0] hold_count;
    logic [15:0] hold_limit;
    logic        timed_flag;
  } seq_state_t;

  seq_state_t st;
  seq_state_t st_next;
  logic [6:0] pwr_delta;
  logic       pwr_step_ok;

  function automatic logic [7:0] step_interval(phase_t ph, cfg_t c);
    logic [7:0] v;
    case (ph)
      PH_MOVE_RAMP:             v = c.move_step_ms;
      PH_STOP_FAST:             v = c.fast_stop_step_ms;
      PH_STOP_SLOW, PH_TURN_PRE: v = c.slow_stop_step_ms;
      PH_TURN_UP:               v = c.turn_up_step_ms;
      default:                  v = 8'd0;
    endcase
    if (v == 8'd0) begin
      v = 8'd1;
    end
    return v;
  endfunction

  function automatic seq_state_t settle_step(seq_state_t s);
    seq_state_t r;
    r = s;
    case (s.phase)
      PH_MOVE_RAMP: begin
        if (s.power_level == s.goal_power) begin
          r.step_count = 8'd0;
          if (!s.timed_flag) begin
            r.phase = PH_IDLE;
          end else if (s.hold_count >= s.hold_limit) begin
            r.goal_power = 7'd0;
            r.phase      = PH_STOP_FAST;
          end else begin
            r.phase = PH_MOVE_HOLD;
          end
        end
      end
      PH_MOVE_HOLD: begin
        if (s.hold_count >= s.hold_limit) begin
          r.goal_power = 7'd0;
          r.phase      = PH_STOP_FAST;
          r.step_count = 8'd0;
        end
      end
      PH_STOP_FAST, PH_STOP_SLOW: begin
        if (s.power_level == 7'd0) begin
          r.phase      = PH_IDLE;
          r.step_count = 8'd0;
        end
      end
      PH_TURN_PRE: begin
        if (s.power_level == 7'd0) begin
          r.left_dir   = s.timed_flag;
          r.right_dir  = ~s.timed_flag;
          r.phase      = PH_TURN_UP;
          r.step_count = 8'd0;
        end
      end
      PH_TURN_UP: begin
        if (s.power_level == s.goal_power) begin
          r.hold_count = 16'd0;
          r.phase      = PH_TURN_HOLD;
          r.step_count = 8'd0;
        end
      end
      PH_TURN_HOLD: begin
        if (s.hold_count >= s.hold_limit) begin
          r.goal_power = 7'd0;
          r.phase      = PH_STOP_SLOW;
          r.step_count = 8'd0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    seq_state_t s;
    logic [6:0] tp;
    logic [7:0] iv;
    logic [7:0] sc;
    logic       idle;
    s    = st;
    tp   = (req.target_power > FULL_POWER) ? FULL_POWER : req.target_power;
    iv   = step_interval(st.phase, cfg);
    sc   = st.step_count + 8'd1;
    idle = (st.phase == PH_IDLE);
    case (req.req_type)
      REQ_MS_TICK: begin
        if (st.phase != PH_IDLE && st.phase != PH_MOVE_HOLD && st.phase != PH_TURN_HOLD) begin
          if (sc >= iv) begin
            s.step_count = 8'd0;
            if (st.power_level < st.goal_power) begin
              s.power_level = st.power_level + 7'd1;
            end else if (st.power_level > st.goal_power) begin
              s.power_level = st.power_level - 7'd1;
            end
          end else begin
            s.step_count = sc;
          end
        end
      end
      REQ_HOLD_TICK: begin
        if ((((st.phase == PH_MOVE_RAMP) || (st.phase == PH_MOVE_HOLD)) && st.timed_flag) ||
            (st.phase == PH_TURN_HOLD)) begin
          if (st.hold_count != HOLD_MAX) begin
            s.hold_count = st.hold_count + 16'd1;
          end
        end
      end
      REQ_MOVE: begin
        if (idle) begin
          s.left_dir   = req.direction;
          s.right_dir  = req.direction;
          s.goal_power = tp;
          s.hold_limit = req.duration_ticks;
          s.hold_count = 16'd0;
          s.timed_flag = req.timed;
          s.phase      = PH_MOVE_RAMP;
          s.step_count = 8'd0;
        end
      end
      REQ_TURN: begin
        if (idle) begin
          s.goal_power = tp;
          s.hold_limit = req.duration_ticks;
          s.hold_count = 16'd0;
          s.timed_flag = req.direction;
          s.phase      = PH_TURN_PRE;
          s.step_count = 8'd0;
        end
      end
      REQ_STOP: begin
        if (idle) begin
          s.goal_power = 7'd0;
          s.phase      = req.slow_stop ? PH_STOP_SLOW : PH_STOP_FAST;
          s.step_count = 8'd0;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < 8; k++) begin
      s = settle_step(s);
    end
    st_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (upd) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      drive.power     <= st_next.power_level;
      drive.left_dir  <= st_next.left_dir;
      drive.right_dir <= st_next.right_dir;
      drive.busy      <= (st_next.phase != PH_IDLE);
    end
  end

  assign pwr_delta   = st_next.power_level - st.power_level;
  assign pwr_step_ok = (pwr_delta == 7'd0) || (pwr_delta == 7'd1) || (pwr_delta == 7'h7F);

  `DMRS_ASSERT(a_power_in_range, clk, rst, st.power_level <= FULL_POWER, "power too high")
  `DMRS_ASSERT(a_power_single_step, clk, rst, pwr_step_ok, "power moved by more than one step")
  `DMRS_ASSERT(a_idle_step_clear, clk, rst, st.phase == PH_IDLE |-> st.step_count == 8'd0, "idle count")

endmodule

@@ src/dmrs_duty_pipe.sv @@
// ----------------------------------------------------------------------------
// Duty calculation pipeline
// Scales the common power by the PWM period over two stages and forms the
// four H-bridge duty bytes.
// ----------------------------------------------------------------------------
module dmrs_duty_pipe
  import dmrs_pkg::*;
(
  input  logic      clk,
  input  cfg_t      cfg,
  input  pipe_ctl_t ctl,
  input  drive_t    drive,
  output result_t   res
);

  logic [14:0] prod_c;
  drive_t      drive_c;
  logic [27:0] scaled;
  logic [7:0]  p;
  logic [7:0]  pos;
  logic [7:0]  neg;

  always_ff @(posedge clk) begin
    if (ctl.load_c) begin
      prod_c  <= 15'(drive.power) * 15'(cfg.pwm_period);
      drive_c <= drive;
    end
  end

  always_comb begin
    scaled = 28'(prod_c) * 28'(RECIP_MUL);
    p      = scaled[RECIP_SHIFT +: 8];
    if (cfg.brake_mode) begin
      pos = cfg.pwm_period - p;
      neg = cfg.pwm_period;
    end else begin
      pos = 8'd0;
      neg = p;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_d) begin
      res.left_pos_duty  <= drive_c.left_dir  ? pos : neg;
      res.left_neg_duty  <= drive_c.left_dir  ? neg : pos;
      res.right_pos_duty <= drive_c.right_dir ? pos : neg;
      res.right_neg_duty <= drive_c.right_dir ? neg : pos;
      res.power_pct      <= drive_c.power;
      res.busy_res       <= drive_c.busy;
    end
  end

endmodule

@@ src/dual_motor_ramp_sequencer.sv @@
// ----------------------------------------------------------------------------
// Dual motor ramp sequencer
// Soft-start sequencer for two H-bridge motors that share one power level.
// ----------------------------------------------------------------------------
// Each transfer on the slave side is a millisecond tick, a hold tick or a
// move, turn or stop command, and it produces exactly one result transfer
// carrying the four duty bytes, the present power and the busy flag. The
// block takes one item per clock while the master side accepts results; a
// result is presented after its item has passed an input register, the
// state update, the power-times-period product and the divide-by-100 stage.
// The state update of one cycle feeds the next, so items may follow each
// other on every clock. Stalls on the master side fill empty stages first.
module dual_motor_ramp_sequencer
  import dmrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // direction[0], target_power[7:1], duration_ticks[23:8], timed[24],
  // slow_stop[25], zero fill[31:26]
  input  logic [31:0]            s_tdata,
  // req_type[2:0]
  input  logic [2:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // left_pos_duty[7:0], left_neg_duty[15:8], right_pos_duty[23:16],
  // right_neg_duty[31:24], power_pct[38:32], busy_res[39]
  output logic [39:0]            m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "dual_motor_ramp_sequencer_assert.svh"

  cfg_t      cfg;
  req_t      req_a;
  drive_t    drive_b;
  result_t   res;
  pipe_ctl_t ctl;

  logic vld_a;
  logic vld_b;
  logic vld_c;
  logic vld_d;
  logic rdy_a;
  logic rdy_b;
  logic rdy_c;
  logic rdy_d;
  logic pipe_full;

  assign rdy_d = !vld_d || m_tready;
  assign rdy_c = !vld_c || rdy_d;
  assign rdy_b = !vld_b || rdy_c;
  assign rdy_a = !vld_a || rdy_b;

  assign s_tready = rdy_a;
  assign m_tvalid = vld_d;

  assign ctl.load_b = vld_a && rdy_b;
  assign ctl.load_c = rdy_c;
  assign ctl.load_d = rdy_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a <= s_tvalid;
      end
      if (rdy_b) begin
        vld_b <= vld_a;
      end
      if (rdy_c) begin
        vld_c <= vld_b;
      end
      if (rdy_d) begin
        vld_d <= vld_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy_a) begin
      req_a.req_type       <= s_tuser;
      req_a.direction      <= s_tdata[0];
      req_a.target_power   <= s_tdata[7:1];
      req_a.duration_ticks <= s_tdata[23:8];
      req_a.timed          <= s_tdata[24];
      req_a.slow_stop      <= s_tdata[25];
    end
  end

  dmrs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmrs_ramp_core u_ramp_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .req   (req_a),
    .upd   (ctl.load_b),
    .drive (drive_b)
  );

  dmrs_duty_pipe u_duty_pipe (
    .clk   (clk),
    .cfg   (cfg),
    .ctl   (ctl),
    .drive (drive_b),
    .res   (res)
  );

  assign m_tdata = {res.busy_res, res.power_pct, res.right_neg_duty,
                    res.right_pos_duty, res.left_neg_duty, res.left_pos_duty};

  assign pipe_full = vld_a && vld_b && vld_c && vld_d && !m_tready;

  `DMRS_ASSERT(a_full_when_not_ready, clk, rst, !s_tready |-> pipe_full, "input blocked early")
  `DMRS_ASSERT(a_update_moves_item, clk, rst, ctl.load_b |=> vld_b, "update without next item")
  `DMRS_ASSERT_ALWAYS(a_reset_empties, clk, $past(rst) |-> !m_tvalid, "valid after reset")

endmodule
